>>> hw/rtl/kmst_pkg.sv
// ----------------------------------------------------------------------------
// kmst_pkg
// Shared widths, defaults and types of the minimum spanning tree block.
// ----------------------------------------------------------------------------
package kmst_pkg;

  // port field widths
  localparam int NODE_W   = 10;
  localparam int WEIGHT_W = 16;
  localparam int COST_W   = 27;
  localparam int CFG_W    = 11;

  // parameter defaults
  localparam int DEF_MAX_NODES   = 1024;
  localparam int DEF_MAX_EDGES   = 4096;
  localparam int DEF_WEIGHT_BITS = 16;

  // cost limits
  localparam logic [COST_W-1:0] COST_MAX  = 27'h3FFFFFF;
  localparam logic [COST_W-1:0] COST_NONE = '1;

  // result of one graph
  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic              dropped;
  } kmst_res_t;

  // sequencer states
  typedef enum logic [4:0] {
    ST_LOAD,
    ST_BUILD,
    ST_CUR_WAIT,
    ST_SIFT,
    ST_L_WAIT,
    ST_R_WAIT,
    ST_SIFT_END,
    ST_SORT,
    ST_S_TOP,
    ST_S_LAST,
    ST_CLR,
    ST_K,
    ST_K_WAIT,
    ST_F1,
    ST_F1W,
    ST_F2,
    ST_F2W,
    ST_UNION,
    ST_DONE
  } kmst_state_e;

endpackage

>>> hw/rtl/kmst_ram.sv
// ----------------------------------------------------------------------------
// kmst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kmst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> hw/rtl/kmst_ctrl.sv
// ----------------------------------------------------------------------------
// kmst_ctrl
// Edge store loading, heap sort over the edge RAM, parent table clearing
// and the union-find pass with path compression.
// ----------------------------------------------------------------------------
module kmst_ctrl #(
  parameter int MAX_NODES   = kmst_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES   = kmst_pkg::DEF_MAX_EDGES,
  parameter int WEIGHT_BITS = kmst_pkg::DEF_WEIGHT_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_fire_i,
  input  logic [kmst_pkg::NODE_W-1:0]        node_a_i,
  input  logic [kmst_pkg::NODE_W-1:0]        node_b_i,
  input  logic [kmst_pkg::WEIGHT_W-1:0]      edge_weight_i,
  input  logic                               last_edge_i,
  input  logic [$clog2(MAX_NODES+1)-1:0]     n_eff_i,
  output logic                               busy_o,
  output logic                               res_valid_o,
  input  logic                               res_take_i,
  output kmst_pkg::kmst_res_t                res_o
);
  import kmst_pkg::*;

  localparam int NIB = $clog2(MAX_NODES);
  localparam int NCB = $clog2(MAX_NODES+1);
  localparam int EA  = $clog2(MAX_EDGES);
  localparam int ET  = $clog2(MAX_EDGES+1);
  localparam int HB  = EA + 2;
  localparam int EW  = WEIGHT_BITS + 2*NODE_W;

  kmst_state_e state_q, state_d;

  logic [ET-1:0]          total_q, total_d;
  logic                   ovf_q, ovf_d;
  logic [ET-1:0]          idx_q, idx_d;
  logic [EA-1:0]          hole_q, hole_d;
  logic [ET-1:0]          len_q, len_d;
  logic [EW-1:0]          cur_q, cur_d;
  logic [EW-1:0]          cl_q, cl_d;
  logic                   sort_ph_q, sort_ph_d;
  logic [NCB-1:0]         n_q, n_d;
  logic [NCB-1:0]         node_q, node_d;
  logic [NIB-1:0]         walk_q, walk_d;
  logic [NIB-1:0]         root_q, root_d;
  logic [NIB-1:0]         ra_q, ra_d;
  logic [NIB-1:0]         eb_q, eb_d;
  logic [NIB-1:0]         start_q, start_d;
  logic                   which_q, which_d;
  logic [WEIGHT_BITS-1:0] ew_q, ew_d;
  logic [COST_W-1:0]      cost_q, cost_d;
  logic [NCB-1:0]         tree_q, tree_d;

  // edge RAM ports
  logic          e_we;
  logic [EA-1:0] e_waddr, e_raddr;
  logic [EW-1:0] e_wdata, e_rdata;

  // parent RAM ports
  logic           p_we;
  logic [NIB-1:0] p_waddr, p_raddr, p_wdata, p_rdata;

  kmst_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (e_wdata),
    .raddr_i (e_raddr),
    .rdata_o (e_rdata)
  );

  kmst_ram #(.WIDTH(NIB), .DEPTH(MAX_NODES)) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  // packed incoming edge: weight, a, b
  logic [WEIGHT_BITS+WEIGHT_W-1:0] w_ext;
  logic [EW-1:0]                   in_word;
  assign w_ext   = {{WEIGHT_BITS{1'b0}}, edge_weight_i};
  assign in_word = {w_ext[WEIGHT_BITS-1:0], node_a_i, node_b_i};

  // heap children of the hole
  logic [HB-1:0] lchild, rchild;
  assign lchild = HB'({hole_q, 1'b1});
  assign rchild = lchild + HB'(1);

  // fields of the edge read in the kruskal pass
  logic [NODE_W-1:0]     rd_a, rd_b;
  logic [NIB+NODE_W-1:0] rd_a_ext, rd_b_ext;
  assign rd_b     = e_rdata[NODE_W-1:0];
  assign rd_a     = e_rdata[2*NODE_W-1:NODE_W];
  assign rd_a_ext = {{NIB{1'b0}}, rd_a};
  assign rd_b_ext = {{NIB{1'b0}}, rd_b};

  // saturating cost add
  logic [32:0] sum_wide;
  assign sum_wide = 33'(cost_q) + 33'(ew_q);

  // child selection for the sift step
  logic [EW-1:0] big_v;
  logic [EA-1:0] big_a;

  // state register and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      total_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    hole_q    <= hole_d;
    len_q     <= len_d;
    cur_q     <= cur_d;
    cl_q      <= cl_d;
    sort_ph_q <= sort_ph_d;
    n_q       <= n_d;
    node_q    <= node_d;
    walk_q    <= walk_d;
    root_q    <= root_d;
    ra_q      <= ra_d;
    eb_q      <= eb_d;
    start_q   <= start_d;
    which_q   <= which_d;
    ew_q      <= ew_d;
    cost_q    <= cost_d;
    tree_q    <= tree_d;
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    total_d   = total_q;
    ovf_d     = ovf_q;
    idx_d     = idx_q;
    hole_d    = hole_q;
    len_d     = len_q;
    cur_d     = cur_q;
    cl_d      = cl_q;
    sort_ph_d = sort_ph_q;
    n_d       = n_q;
    node_d    = node_q;
    walk_d    = walk_q;
    root_d    = root_q;
    ra_d      = ra_q;
    eb_d      = eb_q;
    start_d   = start_q;
    which_d   = which_q;
    ew_d      = ew_q;
    cost_d    = cost_q;
    tree_d    = tree_q;
    e_we      = 1'b0;
    e_waddr   = total_q[EA-1:0];
    e_wdata   = in_word;
    e_raddr   = idx_q[EA-1:0];
    p_we      = 1'b0;
    p_waddr   = walk_q;
    p_wdata   = root_q;
    p_raddr   = walk_q;
    big_v     = cl_q;
    big_a     = lchild[EA-1:0];
    busy_o      = (state_q != ST_LOAD);
    res_valid_o = 1'b0;
    res_o.cost    = (tree_q == n_q - NCB'(1)) ? cost_q : COST_NONE;
    res_o.dropped = ovf_q;

    unique case (state_q)
      ST_LOAD: begin
        if (in_fire_i) begin
          if (total_q < ET'(MAX_EDGES)) begin
            e_we    = 1'b1;
            total_d = total_q + ET'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (last_edge_i) begin
            idx_d     = total_d >> 1;
            n_d       = n_eff_i;
            sort_ph_d = 1'b0;
            state_d   = ST_BUILD;
          end
        end
      end
      // heap build: sift each inner node from the middle down to the root
      ST_BUILD: begin
        if (idx_q == '0) begin
          if (total_q < ET'(2)) begin
            node_d  = '0;
            state_d = ST_CLR;
          end else begin
            idx_d     = total_q - ET'(1);
            sort_ph_d = 1'b1;
            state_d   = ST_SORT;
          end
        end else begin
          e_raddr = EA'(idx_q - ET'(1));
          hole_d  = EA'(idx_q - ET'(1));
          len_d   = total_q;
          idx_d   = idx_q - ET'(1);
          state_d = ST_CUR_WAIT;
        end
      end
      ST_CUR_WAIT: begin
        cur_d   = e_rdata;
        state_d = ST_SIFT;
      end
      // one level of the sift: stop at a leaf
      ST_SIFT: begin
        if (lchild >= HB'(len_q)) begin
          e_we    = 1'b1;
          e_waddr = hole_q;
          e_wdata = cur_q;
          state_d = ST_SIFT_END;
        end else begin
          e_raddr = lchild[EA-1:0];
          state_d = ST_L_WAIT;
        end
      end
      ST_L_WAIT: begin
        cl_d = e_rdata;
        if (rchild < HB'(len_q)) begin
          e_raddr = rchild[EA-1:0];
          state_d = ST_R_WAIT;
        end else begin
          e_we    = 1'b1;
          e_waddr = hole_q;
          if (e_rdata > cur_q) begin
            e_wdata = e_rdata;
            hole_d  = lchild[EA-1:0];
            state_d = ST_SIFT;
          end else begin
            e_wdata = cur_q;
            state_d = ST_SIFT_END;
          end
        end
      end
      ST_R_WAIT: begin
        if (e_rdata > cl_q) begin
          big_v = e_rdata;
          big_a = rchild[EA-1:0];
        end
        e_we    = 1'b1;
        e_waddr = hole_q;
        if (big_v > cur_q) begin
          e_wdata = big_v;
          hole_d  = big_a;
          state_d = ST_SIFT;
        end else begin
          e_wdata = cur_q;
          state_d = ST_SIFT_END;
        end
      end
      ST_SIFT_END: begin
        state_d = sort_ph_q ? ST_SORT : ST_BUILD;
      end
      // sort phase: move the maximum behind the heap, sift the tail value
      ST_SORT: begin
        if (idx_q == '0) begin
          node_d  = '0;
          state_d = ST_CLR;
        end else begin
          e_raddr = '0;
          state_d = ST_S_TOP;
        end
      end
      ST_S_TOP: begin
        cl_d    = e_rdata;
        e_raddr = idx_q[EA-1:0];
        state_d = ST_S_LAST;
      end
      ST_S_LAST: begin
        cur_d   = e_rdata;
        e_we    = 1'b1;
        e_waddr = idx_q[EA-1:0];
        e_wdata = cl_q;
        hole_d  = '0;
        len_d   = idx_q;
        idx_d   = idx_q - ET'(1);
        state_d = ST_SIFT;
      end
      // every node in use becomes its own root
      ST_CLR: begin
        p_we    = 1'b1;
        p_waddr = node_q[NIB-1:0];
        p_wdata = node_q[NIB-1:0];
        node_d  = node_q + NCB'(1);
        if (node_q == n_q - NCB'(1)) begin
          idx_d   = '0;
          cost_d  = '0;
          tree_d  = '0;
          state_d = ST_K;
        end
      end
      // kruskal edge loop
      ST_K: begin
        if (idx_q >= total_q || tree_q >= n_q) begin
          state_d = ST_DONE;
        end else begin
          e_raddr = idx_q[EA-1:0];
          state_d = ST_K_WAIT;
        end
      end
      ST_K_WAIT: begin
        idx_d = idx_q + ET'(1);
        ew_d  = e_rdata[EW-1:2*NODE_W];
        if (32'(rd_a) >= 32'(n_q) || 32'(rd_b) >= 32'(n_q)) begin
          state_d = ST_K;
        end else begin
          walk_d  = rd_a_ext[NIB-1:0];
          start_d = rd_a_ext[NIB-1:0];
          eb_d    = rd_b_ext[NIB-1:0];
          which_d = 1'b0;
          state_d = ST_F1;
        end
      end
      // root search: one parent read per cycle
      ST_F1: begin
        p_raddr = walk_q;
        state_d = ST_F1W;
      end
      ST_F1W: begin
        if (p_rdata == walk_q) begin
          root_d  = walk_q;
          walk_d  = start_q;
          state_d = ST_F2;
        end else begin
          walk_d  = p_rdata;
          p_raddr = p_rdata;
        end
      end
      // path compression: hang each node of the path below the root
      ST_F2: begin
        p_raddr = walk_q;
        state_d = ST_F2W;
      end
      ST_F2W: begin
        if (p_rdata == root_q) begin
          if (!which_q) begin
            ra_d    = root_q;
            walk_d  = eb_q;
            start_d = eb_q;
            which_d = 1'b1;
            state_d = ST_F1;
          end else begin
            state_d = ST_UNION;
          end
        end else begin
          p_we    = 1'b1;
          p_waddr = walk_q;
          p_wdata = root_q;
          walk_d  = p_rdata;
          p_raddr = p_rdata;
        end
      end
      // join the trees and add the weight
      ST_UNION: begin
        if (ra_q != root_q) begin
          p_we    = 1'b1;
          p_waddr = ra_q;
          p_wdata = root_q;
          tree_d  = tree_q + NCB'(1);
          cost_d  = (sum_wide > 33'(COST_MAX)) ? COST_MAX : sum_wide[COST_W-1:0];
        end
        state_d = ST_K;
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          total_d = '0;
          ovf_d   = 1'b0;
          state_d = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule

>>> hw/rtl/kruskal_minimum_spanning_tree.sv
// ----------------------------------------------------------------------------
// kruskal_minimum_spanning_tree
// Minimum spanning tree cost of a loaded edge list, heap sort plus
// union-find over two synchronous RAMs.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  in       input      in_valid/in_stall  node_a, node_b, edge_weight, last_edge
//  out      output     out_valid/out_stall tree_cost, edges_dropped
//  cfg      input      cfg_valid/cfg_ready node_count
//
//  loading accepts an edge whenever in_stall is low; the last edge starts the computation
//  each sift level reads both children and writes the hole in turn (one edge RAM port)
//  parent clearing writes each node in use in turn, then each find makes one parent read
//  per step plus the compression walk (one parent RAM port)
//  reset clears control state only; in_stall is high during computation
//  a result not yet taken keeps in_stall high and blocks loading of the next graph
// ----------------------------------------------------------------------------
module kruskal_minimum_spanning_tree #(
  parameter int MAX_NODES   = kmst_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES   = kmst_pkg::DEF_MAX_EDGES,
  parameter int WEIGHT_BITS = kmst_pkg::DEF_WEIGHT_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [kmst_pkg::NODE_W-1:0]          node_a_i,
  input  logic [kmst_pkg::NODE_W-1:0]          node_b_i,
  input  logic [kmst_pkg::WEIGHT_W-1:0]        edge_weight_i,
  input  logic                                 last_edge_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [kmst_pkg::COST_W-1:0]   tree_cost_o,
  output logic                                 edges_dropped_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [kmst_pkg::CFG_W-1:0]           cfg_data_i
);
  import kmst_pkg::*;

  localparam int NCB = $clog2(MAX_NODES+1);

  logic [CFG_W-1:0] node_count_q;
  logic [NCB-1:0]   n_eff;
  logic             busy, res_valid, out_free, out_valid_q;
  kmst_res_t        res, res_q;

  // configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CFG_W'(1);
    end else if (cfg_valid_i) begin
      node_count_q <= cfg_data_i;
    end
  end

  // clamp node count to the table range
  always_comb begin
    priority if (node_count_q == '0) begin
      n_eff = NCB'(1);
    end else if (32'(node_count_q) > 32'(MAX_NODES)) begin
      n_eff = NCB'(MAX_NODES);
    end else begin
      n_eff = NCB'(node_count_q);
    end
  end

  assign in_stall_o = busy;
  assign out_free   = !out_valid_q || !out_stall_i;

  kmst_ctrl #(
    .MAX_NODES   (MAX_NODES),
    .MAX_EDGES   (MAX_EDGES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_fire_i     (in_valid_i && !busy),
    .node_a_i      (node_a_i),
    .node_b_i      (node_b_i),
    .edge_weight_i (edge_weight_i),
    .last_edge_i   (last_edge_i),
    .n_eff_i       (n_eff),
    .busy_o        (busy),
    .res_valid_o   (res_valid),
    .res_take_i    (out_free),
    .res_o         (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res_valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign tree_cost_o     = signed'(res_q.cost);
  assign edges_dropped_o = res_q.dropped;

endmodule

>>> test/kmst_checker.sv
// ----------------------------------------------------------------------------
// kmst_checker
// Watches the edge, result and configuration channels of the spanning tree
// block, predicts the cost of every loaded graph and compares each result.
// ----------------------------------------------------------------------------
module kmst_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic [kmst_pkg::NODE_W-1:0]         node_a_i,
  input  logic [kmst_pkg::NODE_W-1:0]         node_b_i,
  input  logic [kmst_pkg::WEIGHT_W-1:0]       edge_weight_i,
  input  logic                                last_edge_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic [kmst_pkg::COST_W-1:0]         tree_cost_i,
  input  logic                                edges_dropped_i,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [kmst_pkg::CFG_W-1:0]          cfg_data_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);
  import kmst_pkg::*;

  localparam int EDGE_CAP  = DEF_MAX_EDGES;
  localparam int NODE_CAP  = DEF_MAX_NODES;

  // packed edge: weight, node a, node b, so the sort key follows tie order
  typedef logic [WEIGHT_W+2*NODE_W-1:0] edge_key_t;

  edge_key_t       graph_edges[$];
  kmst_res_t       cost_queue[$];
  logic [CFG_W-1:0] node_count;
  logic            store_full_seen;
  int              parent[NODE_CAP];

  function automatic int root_of(int v);
    int r;
    int nxt;
    r = v;
    while (parent[r] != r) r = parent[r];
    while (parent[v] != r) begin
      nxt = parent[v];
      parent[v] = r;
      v = nxt;
    end
    return r;
  endfunction

  // kruskal pass over the sorted edge list
  function automatic kmst_res_t spanning_cost();
    kmst_res_t res;
    int n;
    int used;
    int ea;
    int eb;
    int ra;
    int rb;
    logic [COST_W-1:0] sum;
    n = (int'(node_count) < 1) ? 1 :
        ((int'(node_count) > NODE_CAP) ? NODE_CAP : int'(node_count));
    graph_edges.sort();
    for (int i = 0; i < NODE_CAP; i++) parent[i] = i;
    sum  = '0;
    used = 0;
    foreach (graph_edges[i]) begin
      if (used >= n) break;
      ea = int'(graph_edges[i][2*NODE_W-1:NODE_W]);
      eb = int'(graph_edges[i][NODE_W-1:0]);
      if (ea >= n || eb >= n) continue;
      ra = root_of(ea);
      rb = root_of(eb);
      if (ra != rb) begin
        sum = sum + COST_W'(graph_edges[i][WEIGHT_W+2*NODE_W-1:2*NODE_W]);
        if (sum > COST_MAX) sum = COST_MAX;
        used++;
        parent[ra] = rb;
      end
    end
    res.cost    = (used == n - 1) ? sum : COST_NONE;
    res.dropped = store_full_seen;
    return res;
  endfunction

  assign pending_o = cost_queue.size();

  always @(posedge clk_i or negedge rst_ni) begin
    kmst_res_t exp_res;
    if (!rst_ni) begin
      node_count      <= CFG_W'(1);
      store_full_seen = 1'b0;
      fail_count_o    <= 0;
      graph_edges.delete();
      cost_queue.delete();
    end else begin
      // configuration transaction
      if (cfg_valid_i && cfg_ready_i) node_count <= cfg_data_i;

      // edge transaction
      if (in_valid_i && !in_stall_i) begin
        if (graph_edges.size() < EDGE_CAP)
          graph_edges.insert(graph_edges.size(), {edge_weight_i, node_a_i, node_b_i});
        else
          store_full_seen = 1'b1;
        if (last_edge_i) begin
          cost_queue.insert(cost_queue.size(), spanning_cost());
          graph_edges.delete();
          store_full_seen = 1'b0;
        end
      end

      // result transaction
      if (out_valid_i && !out_stall_i) begin
        if (cost_queue.size() == 0) begin
          $error("unexpected result: tree_cost %0d edges_dropped %0b",
                 $signed(tree_cost_i), edges_dropped_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_res = cost_queue.pop_front();
          if (tree_cost_i !== exp_res.cost || edges_dropped_i !== exp_res.dropped) begin
            if (tree_cost_i !== exp_res.cost)
              $error("tree_cost: expected %0d actual %0d",
                     $signed(exp_res.cost), $signed(tree_cost_i));
            if (edges_dropped_i !== exp_res.dropped)
              $error("edges_dropped: expected %0b actual %0b",
                     exp_res.dropped, edges_dropped_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

>>> test/kruskal_minimum_spanning_tree_test.sv
// ----------------------------------------------------------------------------
// kruskal_minimum_spanning_tree_test
// Feeds directed and random weighted graphs under several node counts,
// with random gaps and a long result hold-off; the checker predicts every
// spanning tree cost.
// ----------------------------------------------------------------------------
module kruskal_minimum_spanning_tree_test;
  import kmst_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int HOLD_CYCLES = 3000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [NODE_W-1:0]   node_a;
  logic [NODE_W-1:0]   node_b;
  logic [WEIGHT_W-1:0] edge_weight;
  logic                last_edge;
  logic                out_valid;
  logic                out_stall;
  logic [COST_W-1:0]   tree_cost;
  logic                edges_dropped;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_data;
  int                  fail_count;
  int                  pending;
  int                  cycle_count;
  int                  edges_sent;
  int                  n_cur;
  int                  hold_tag;
  bit                  no_idle;

  kruskal_minimum_spanning_tree i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .node_a_i       (node_a),
    .node_b_i       (node_b),
    .edge_weight_i  (edge_weight),
    .last_edge_i    (last_edge),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .tree_cost_o    (tree_cost),
    .edges_dropped_o(edges_dropped),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data)
  );

  kmst_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .node_a_i       (node_a),
    .node_b_i       (node_b),
    .edge_weight_i  (edge_weight),
    .last_edge_i    (last_edge),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .tree_cost_i    (tree_cost),
    .edges_dropped_i(edges_dropped),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side stall, with random gaps and a long hold-off on request
  initial begin
    int  gap;
    int  hold_left;
    int  hold_seen;
    bit  took;
    out_stall = 1'b1;
    gap       = 0;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      took = out_valid && !out_stall;
      @(negedge clk);
      if (hold_tag != hold_seen) begin
        hold_seen = hold_tag;
        hold_left = HOLD_CYCLES;
      end
      if (took) gap = (no_idle || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (gap > 0) begin
        gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // one edge transaction; valid stays high until the next gap
  task automatic send_edge(int a, int b, int w, bit last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    node_a      <= NODE_W'(a);
    node_b      <= NODE_W'(b);
    edge_weight <= WEIGHT_W'(w);
    last_edge   <= last;
    in_valid    <= 1'b1;
    do @(posedge clk); while (in_stall);
    edges_sent++;
  endtask

  // let every expected result arrive, then leave the block settling
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_node_count(int value);
    drain();
    @(negedge clk);
    cfg_data  <= CFG_W'(value);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    n_cur = (value < 1) ? 1 : ((value > 1024) ? 1024 : value);
  endtask

  // random graph: mostly a spanning chain plus extras, sometimes noise
  task automatic send_graph();
    int cnt;
    int wmax;
    int order[$];
    bit wild;
    wild = ($urandom_range(0, 4) == 0);
    wmax = ($urandom_range(0, 2) == 0) ? 3 : 65535;
    for (int i = 0; i < n_cur && i < 64; i++) order.insert(order.size(), i);
    order.shuffle();
    if (!wild) begin
      for (int i = 1; i < order.size(); i++)
        send_edge(order[i-1], order[i], $urandom_range(0, wmax), 1'b0);
    end
    cnt = $urandom_range(0, 6);
    for (int i = 0; i < cnt; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_edge($urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 65535), 1'b0);
      else
        send_edge($urandom_range(0, n_cur - 1), $urandom_range(0, n_cur - 1),
                  $urandom_range(0, wmax), 1'b0);
    end
    send_edge($urandom_range(0, n_cur - 1), $urandom_range(0, n_cur - 1),
              $urandom_range(0, wmax), 1'b1);
  endtask

  initial begin
    int choice;
    in_valid    = 1'b0;
    node_a      = '0;
    node_b      = '0;
    edge_weight = '0;
    last_edge   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    hold_tag    = 0;
    no_idle     = 1'b0;
    edges_sent  = 0;
    n_cur       = 1;
    rst_n       = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset node count, single node graph
    send_edge(0, 0, 65535, 1'b1);
    // zero acts as one node
    write_node_count(0);
    send_edge(0, 0, 12, 1'b0);
    send_edge(1023, 1023, 65535, 1'b1);
    // four nodes with ties, heavy weight and out-of-range endpoints
    write_node_count(4);
    send_edge(0, 1, 0, 1'b0);
    send_edge(1, 2, 65535, 1'b0);
    send_edge(2, 3, 7, 1'b0);
    send_edge(0, 3, 7, 1'b0);
    send_edge(5, 1, 1, 1'b0);
    send_edge(1023, 0, 0, 1'b0);
    send_edge(3, 3, 2, 1'b1);
    // disconnected graph
    send_edge(0, 1, 3, 1'b0);
    send_edge(2, 2, 4, 1'b1);
    // largest count, clamped
    write_node_count(2047);
    send_edge(682, 341, 43690, 1'b0);
    send_edge(0, 1, 21845, 1'b1);
    write_node_count(1024);
    send_edge(1023, 0, 1, 1'b1);

    // random graphs under changing node counts
    while (edges_sent < 1450) begin
      choice = $urandom_range(0, 19);
      if (choice == 0)      write_node_count($urandom_range(1000, 2047));
      else if (choice == 1) write_node_count(0);
      else                  write_node_count($urandom_range(1, 12));
      no_idle = ($urandom_range(0, 3) == 0);
      // long result hold-off so the block backs up its edge input
      if (choice == 5 || edges_sent > 700 && hold_tag == 0) hold_tag++;
      repeat ($urandom_range(1, 6)) send_graph();
    end

    drain();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
